/* sv/tn4_pkg.sv */
`timescale 1ns / 1ps

package tn4_pkg;

    localparam int EXTENT_MAX      = 256;
    localparam int EXT_W           = 9;
    localparam int COORD_W         = 8;
    localparam int RANK_W          = 32;
    localparam int BYTES_W         = 31;
    localparam int DIR_W           = 3;
    localparam int NUM_DIMS        = 4;
    localparam int STEPS_PER_STAGE = 8;
    localparam int STAGES_PER_DIM  = RANK_W / STEPS_PER_STAGE;
    localparam int DIV_STAGES      = STAGES_PER_DIM * NUM_DIMS;
    localparam int CFG_IDX_W       = 3;
    localparam int STRIDE_2_W      = 17;
    localparam int STRIDE_3_W      = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_X,
        REG_EXTENT_Y,
        REG_EXTENT_Z,
        REG_EXTENT_T,
        REG_MESSAGE_BYTES
    } cfg_reg_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_X_MINUS,
        DIR_X_PLUS,
        DIR_Y_MINUS,
        DIR_Y_PLUS,
        DIR_Z_MINUS,
        DIR_Z_PLUS,
        DIR_T_MINUS,
        DIR_T_PLUS
    } dir_t;

    typedef struct packed {
        logic [NUM_DIMS-1:0][EXT_W-1:0]  extent;
        logic [NUM_DIMS-1:0][RANK_W-1:0] stride;
        logic [NUM_DIMS-1:0][RANK_W-1:0] span;
    } geom_t;

    typedef struct packed {
        logic [RANK_W-1:0]                 rank;
        logic [NUM_DIMS-2:0][COORD_W-1:0]  coord;
        logic [COORD_W-1:0]                rem;
        logic [RANK_W-1:0]                 work;
    } div_item_t;

    typedef struct packed {
        logic [RANK_W-1:0]                 rank;
        logic [NUM_DIMS-1:0][COORD_W-1:0]  coord;
        logic                              oor;
    } emit_item_t;

    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] raw);
        logic [EXT_W-1:0] res;
        if (raw == '0)
            res = EXT_W'(1);
        else if (raw > EXT_W'(EXTENT_MAX))
            res = EXT_W'(EXTENT_MAX);
        else
            res = raw;
        return res;
    endfunction

endpackage

/* sv/tn4_cfg.sv */
`timescale 1ns / 1ps

module tn4_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tn4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tn4_pkg::BYTES_W-1:0]   cfg_data,
    output tn4_pkg::geom_t                geom,
    output logic [tn4_pkg::BYTES_W-1:0]   message_bytes
);
    import tn4_pkg::*;

    logic [NUM_DIMS-1:0][EXT_W-1:0] ext_reg;
    logic [BYTES_W-1:0]             bytes_reg;
    logic [NUM_DIMS-1:0][EXT_W-1:0] eff;
    logic [STRIDE_2_W-1:0]          stride2_reg;
    logic [STRIDE_3_W-1:0]          stride3_reg;
    logic [RANK_W-1:0]              span1_reg;
    logic [RANK_W-1:0]              span2_reg;
    logic [RANK_W-1:0]              span3_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg   <= {NUM_DIMS{EXT_W'(1)}};
            bytes_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_EXTENT_X:      ext_reg[0] <= cfg_data[EXT_W-1:0];
                REG_EXTENT_Y:      ext_reg[1] <= cfg_data[EXT_W-1:0];
                REG_EXTENT_Z:      ext_reg[2] <= cfg_data[EXT_W-1:0];
                REG_EXTENT_T:      ext_reg[3] <= cfg_data[EXT_W-1:0];
                REG_MESSAGE_BYTES: bytes_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
            eff[d] = eff_extent(ext_reg[d]);
    end

    // Strides and spans are registered (stride2, then stride3/span2, then span3)
    // and settle after a write, well ahead of the first item reaching the emitter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride2_reg <= STRIDE_2_W'(1);
            stride3_reg <= STRIDE_3_W'(1);
            span1_reg   <= '0;
            span2_reg   <= '0;
            span3_reg   <= '0;
        end
        else
        begin
            stride2_reg <= STRIDE_2_W'(RANK_W'(eff[0]) * RANK_W'(eff[1]));
            stride3_reg <= STRIDE_3_W'(RANK_W'(stride2_reg) * RANK_W'(eff[2]));
            span1_reg   <= RANK_W'(eff[1] - EXT_W'(1)) * RANK_W'(eff[0]);
            span2_reg   <= RANK_W'(eff[2] - EXT_W'(1)) * RANK_W'(stride2_reg);
            span3_reg   <= RANK_W'(eff[3] - EXT_W'(1)) * RANK_W'(stride3_reg);
        end
    end

    always_comb
    begin
        geom.extent    = eff;
        geom.stride[0] = RANK_W'(1);
        geom.stride[1] = RANK_W'(eff[0]);
        geom.stride[2] = RANK_W'(stride2_reg);
        geom.stride[3] = RANK_W'(stride3_reg);
        geom.span[0]   = RANK_W'(eff[0] - EXT_W'(1));
        geom.span[1]   = span1_reg;
        geom.span[2]   = span2_reg;
        geom.span[3]   = span3_reg;
    end

    assign message_bytes = bytes_reg;

endmodule

/* sv/tn4_div_stage.sv */
`timescale 1ns / 1ps

module tn4_div_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tn4_pkg::div_item_t         in_data,
    input  logic [tn4_pkg::EXT_W-1:0]  extent,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tn4_pkg::div_item_t         out_data
);
    import tn4_pkg::*;

    logic      valid_reg;
    div_item_t data_reg;
    div_item_t data_next;

    // Restoring division, one quotient bit per step, dividend shifted out MSB first.
    always_comb
    begin
        logic [EXT_W-1:0]   rr;
        logic [COORD_W-1:0] r;
        logic [RANK_W-1:0]  w;
        r = in_data.rem;
        w = in_data.work;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            rr = {r, w[RANK_W-1]};
            w  = {w[RANK_W-2:0], 1'b0};
            if (rr >= extent)
            begin
                rr   = rr - extent;
                w[0] = 1'b1;
            end
            r = rr[COORD_W-1:0];
        end
        data_next      = in_data;
        data_next.rem  = r;
        data_next.work = w;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/tn4_emit.sv */
`timescale 1ns / 1ps

module tn4_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tn4_pkg::emit_item_t           in_item,
    input  tn4_pkg::geom_t                geom,
    input  logic [tn4_pkg::BYTES_W-1:0]   message_bytes,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tn4_pkg::RANK_W-1:0]    from_rank,
    output logic [tn4_pkg::RANK_W-1:0]    neighbor_rank,
    output logic [tn4_pkg::BYTES_W-1:0]   edge_bytes,
    output logic [tn4_pkg::DIR_W-1:0]     direction,
    output logic                          out_of_range,
    output logic                          last_of_run
);
    import tn4_pkg::*;

    emit_item_t         item_reg;
    logic               item_valid_reg;
    logic [DIR_W-1:0]   k_reg;
    logic               out_valid_reg;
    logic [RANK_W-1:0]  from_reg;
    logic [RANK_W-1:0]  nb_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [DIR_W-1:0]   dir_reg;
    logic               oor_reg;
    logic               last_reg;

    logic               slot_free;
    logic               load;
    logic               last_beat;
    logic [1:0]         dim;
    logic [COORD_W-1:0] c;
    logic [EXT_W-1:0]   e;
    logic [RANK_W-1:0]  stride;
    logic [RANK_W-1:0]  span;
    logic [RANK_W-1:0]  nb_next;

    assign slot_free = !out_valid_reg || !out_stall;
    assign load      = item_valid_reg && slot_free;
    assign last_beat = (k_reg == DIR_T_PLUS);
    assign in_ready  = !item_valid_reg || (load && last_beat);

    assign dim    = k_reg[DIR_W-1:1];
    assign c      = item_reg.coord[dim];
    assign e      = geom.extent[dim];
    assign stride = geom.stride[dim];
    assign span   = geom.span[dim];

    // Step one coordinate, wrapping at either face of the torus; an out-of-range rank gives zero.
    always_comb
    begin
        if (item_reg.oor)
            nb_next = '0;
        else if (!k_reg[0])
            nb_next = (c == '0) ? item_reg.rank + span : item_reg.rank - stride;
        else
            nb_next = (EXT_W'(c) == e - EXT_W'(1)) ? item_reg.rank - span
                                                   : item_reg.rank + stride;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                item_valid_reg <= 1'b1;
                k_reg          <= '0;
            end
            else
            begin
                if (load)
                    k_reg <= k_reg + DIR_W'(1);
                if (load && last_beat)
                    item_valid_reg <= 1'b0;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
        if (load)
        begin
            from_reg  <= item_reg.rank;
            nb_reg    <= nb_next;
            bytes_reg <= message_bytes;
            dir_reg   <= k_reg;
            oor_reg   <= item_reg.oor;
            last_reg  <= last_beat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign from_rank     = from_reg;
    assign neighbor_rank = nb_reg;
    assign edge_bytes    = bytes_reg;
    assign direction     = dir_reg;
    assign out_of_range  = oor_reg;
    assign last_of_run   = last_reg;

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> neighbor_rank == '0)
        else $error("out-of-range beat carries a neighbour rank");

    a_last_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last_of_run != (direction == DIR_T_PLUS)) |-> 1'b0)
        else $error("last flag not on the final direction");

    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("run broken before its last beat");

    a_dir_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> direction == $past(direction) + DIR_W'(1))
        else $error("directions out of order within a run");

endmodule

/* sv/torus_4d_neighbor_ranks_unit.sv */
`timescale 1ns / 1ps

// 4D torus nearest-neighbour unit.
// Input channel (in_valid / in_stall, source_rank): one linear rank per beat.
// The rank is split into x, y, z, t coordinates (x fastest) by a 16-stage
// pipelined divider, eight quotient bits per stage, four stages per dimension.
// Output channel (out_valid / out_stall): eight beats per rank, directions
// x-1, x+1, y-1, y+1, z-1, z+1, t-1, t+1, last_of_run on the eighth.
// A rank passes the divider stages, the emitter item and output registers;
// later beats follow one per cycle while out_stall is low. Sustained rate is
// one rank per eight beats, set by the single output port. Unless stalled,
// the divider takes a rank every cycle and buffers up to 16, the emitter one.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): extents x, y, z,
// t at indexes 0..3 and message size at 4; cfg_ready is always high. Write
// only while the unit is empty.
// Reset clears all valid bits and sets every extent to 1, message size to 0.
// When out_stall is high the current beat holds; backpressure runs back
// through the divider stages to in_stall, and nothing is lost or repeated.

module torus_4d_neighbor_ranks_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tn4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tn4_pkg::BYTES_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tn4_pkg::RANK_W-1:0]    source_rank,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tn4_pkg::RANK_W-1:0]    from_rank,
    output logic [tn4_pkg::RANK_W-1:0]    neighbor_rank,
    output logic [tn4_pkg::BYTES_W-1:0]   edge_bytes,
    output logic [tn4_pkg::DIR_W-1:0]     direction,
    output logic                          out_of_range,
    output logic                          last_of_run
);
    import tn4_pkg::*;

    geom_t              geom;
    logic [BYTES_W-1:0] message_bytes;

    div_item_t                stg_in   [DIV_STAGES];
    div_item_t                stg_out  [DIV_STAGES];
    logic [DIV_STAGES-1:0]    stg_vin;
    logic [DIV_STAGES-1:0]    stg_vout;
    logic [DIV_STAGES-1:0]    stg_rin;
    logic [DIV_STAGES-1:0]    stg_rout;
    emit_item_t               emit_item;
    logic                     emit_ready;

    tn4_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .geom          (geom),
        .message_bytes (message_bytes)
    );

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        if (s == 0)
        begin : g_first
            always_comb
            begin
                stg_in[s].rank  = source_rank;
                stg_in[s].coord = '0;
                stg_in[s].rem   = '0;
                stg_in[s].work  = source_rank;
            end
            assign stg_vin[s] = in_valid;
        end
        else if ((s % STAGES_PER_DIM) == 0)
        begin : g_dim
            // Bank the finished remainder as a coordinate, divide the quotient next.
            always_comb
            begin
                stg_in[s]     = stg_out[s-1];
                stg_in[s].rem = '0;
                stg_in[s].coord[s/STAGES_PER_DIM-1] = stg_out[s-1].rem;
            end
            assign stg_vin[s] = stg_vout[s-1];
        end
        else
        begin : g_mid
            assign stg_in[s]  = stg_out[s-1];
            assign stg_vin[s] = stg_vout[s-1];
        end

        if (s == DIV_STAGES - 1)
        begin : g_rlast
            assign stg_rout[s] = emit_ready;
        end
        else
        begin : g_rmid
            assign stg_rout[s] = stg_rin[s+1];
        end

        tn4_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_vin[s]),
            .in_ready  (stg_rin[s]),
            .in_data   (stg_in[s]),
            .extent    (geom.extent[s/STAGES_PER_DIM]),
            .out_valid (stg_vout[s]),
            .out_ready (stg_rout[s]),
            .out_data  (stg_out[s])
        );
    end

    assign in_stall = !stg_rin[0];

    // A quotient left over after the t division means the rank is off the torus.
    always_comb
    begin
        emit_item.rank     = stg_out[DIV_STAGES-1].rank;
        emit_item.coord[0] = stg_out[DIV_STAGES-1].coord[0];
        emit_item.coord[1] = stg_out[DIV_STAGES-1].coord[1];
        emit_item.coord[2] = stg_out[DIV_STAGES-1].coord[2];
        emit_item.coord[3] = stg_out[DIV_STAGES-1].rem;
        emit_item.oor      = (stg_out[DIV_STAGES-1].work != '0);
    end

    tn4_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stg_vout[DIV_STAGES-1]),
        .in_ready      (emit_ready),
        .in_item       (emit_item),
        .geom          (geom),
        .message_bytes (message_bytes),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .from_rank     (from_rank),
        .neighbor_rank (neighbor_rank),
        .edge_bytes    (edge_bytes),
        .direction     (direction),
        .out_of_range  (out_of_range),
        .last_of_run   (last_of_run)
    );

endmodule

/* verif/torus_4d_neighbor_ranks_unit_tb.sv */
`timescale 1ns / 1ps

module torus_4d_neighbor_ranks_unit_tb;
    import tn4_pkg::*;

    typedef struct {
        logic [RANK_W-1:0]  from_rank;
        logic [RANK_W-1:0]  neighbor_rank;
        logic [BYTES_W-1:0] edge_bytes;
        dir_t               direction;
        logic               out_of_range;
        logic               last_of_run;
    } edge_beat_t;

    localparam int IDLE_LIMIT = 4000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTES_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [RANK_W-1:0]    source_rank;
    logic                 out_valid;
    logic                 out_stall;
    logic [RANK_W-1:0]    from_rank;
    logic [RANK_W-1:0]    neighbor_rank;
    logic [BYTES_W-1:0]   edge_bytes;
    logic [DIR_W-1:0]     direction;
    logic                 out_of_range;
    logic                 last_of_run;

    // predictor copy of the register file
    logic [EXT_W-1:0]   ext_reg [NUM_DIMS];
    logic [BYTES_W-1:0] msg_reg;

    logic [RANK_W-1:0] pending_ranks [$];
    edge_beat_t        expected_edges [$];
    int                mismatches;
    int                idle_cycles;
    int                hold_off;
    bit                stimulus_done;
    bit                in_taken;

    torus_4d_neighbor_ranks_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_rank   (source_rank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .from_rank     (from_rank),
        .neighbor_rank (neighbor_rank),
        .edge_bytes    (edge_bytes),
        .direction     (direction),
        .out_of_range  (out_of_range),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned extent_of(input logic [EXT_W-1:0] raw);
        longint unsigned e;
        e = raw;
        if (e == 0)
            e = 1;
        else if (e > EXTENT_MAX)
            e = EXTENT_MAX;
        return e;
    endfunction

    task automatic predict_neighbours(input logic [RANK_W-1:0] rank);
        longint unsigned ext [NUM_DIMS];
        longint unsigned crd [NUM_DIMS];
        longint unsigned str [NUM_DIMS];
        longint unsigned rest;
        longint unsigned nc;
        longint unsigned nb;
        bit              oor;
        int              dim;
        edge_beat_t      b;
        for (int d = 0; d < NUM_DIMS; d++)
            ext[d] = extent_of(ext_reg[d]);
        str[0] = 1;
        for (int d = 1; d < NUM_DIMS; d++)
            str[d] = str[d-1] * ext[d-1];
        oor  = (longint'(rank) >= str[3] * ext[3]);
        rest = rank;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            crd[d] = rest % ext[d];
            rest   = rest / ext[d];
        end
        for (int k = 0; k < 8; k++)
        begin
            nb = 0;
            if (!oor)
            begin
                dim = k >> 1;
                if (k & 1)
                    nc = (crd[dim] + 1 >= ext[dim]) ? 0 : crd[dim] + 1;
                else
                    nc = (crd[dim] == 0) ? ext[dim] - 1 : crd[dim] - 1;
                nb = rank - crd[dim] * str[dim] + nc * str[dim];
            end
            b.from_rank     = rank;
            b.neighbor_rank = nb[RANK_W-1:0];
            b.edge_bytes    = msg_reg;
            b.direction     = dir_t'(k);
            b.out_of_range  = oor;
            b.last_of_run   = (k == 7);
            expected_edges.push_back(b);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [BYTES_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= REG_EXTENT_T)
            ext_reg[idx] = val[EXT_W-1:0];
        else
            msg_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_torus(input int ex, input int ey, input int ez, input int et,
                             input logic [BYTES_W-1:0] msg);
        write_reg(REG_EXTENT_X, BYTES_W'(ex));
        write_reg(REG_EXTENT_Y, BYTES_W'(ey));
        write_reg(REG_EXTENT_Z, BYTES_W'(ez));
        write_reg(REG_EXTENT_T, BYTES_W'(et));
        write_reg(REG_MESSAGE_BYTES, msg);
    endtask

    // hand over to the driver and wait for the unit to drain
    task automatic run_and_drain();
        while (pending_ranks.size() != 0 || expected_edges.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [RANK_W-1:0] pick_rank(input longint unsigned size);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return RANK_W'($urandom_range(0, int'(size - 1 > 32'h7fffffff ?
                                               32'h7fffffff : size - 1)));
        else if (r == 7)
            return RANK_W'(size - 1);
        else if (r == 8 && size < 64'h1_0000_0000)
            return RANK_W'(size);
        return $urandom();
    endfunction

    task automatic random_phase(input int items);
        longint unsigned size;
        size = 1;
        for (int d = 0; d < NUM_DIMS; d++)
            size = size * extent_of(ext_reg[d]);
        for (int i = 0; i < items; i++)
            pending_ranks.push_back(pick_rank(size));
        run_and_drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        stimulus_done = 1'b0;
        for (int d = 0; d < NUM_DIMS; d++)
            ext_reg[d] = 1;
        msg_reg = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset extents: every rank but zero is out of range
        pending_ranks.push_back(0);
        pending_ranks.push_back(1);
        pending_ranks.push_back(32'hffff_ffff);
        run_and_drain();

        set_torus(4, 3, 5, 2, 31'h7fff_ffff);
        foreach (pending_ranks[i]) ;
        pending_ranks.push_back(0);
        pending_ranks.push_back(3);
        pending_ranks.push_back(4);
        pending_ranks.push_back(59);
        pending_ranks.push_back(119);
        pending_ranks.push_back(120);
        pending_ranks.push_back(32'h8000_0000);
        run_and_drain();

        // zero acts as one, above the maximum saturates
        set_torus(0, 511, 257, 0, 31'h5555_5555);
        pending_ranks.push_back(0);
        pending_ranks.push_back(255);
        pending_ranks.push_back(256);
        pending_ranks.push_back(1000);
        run_and_drain();

        // largest torus: every rank is in range
        set_torus(256, 256, 256, 256, '0);
        pending_ranks.push_back(0);
        pending_ranks.push_back(32'hffff_ffff);
        pending_ranks.push_back(32'h0100_00ff);
        pending_ranks.push_back(32'haaaa_aaaa);
        pending_ranks.push_back(32'h5555_5555);
        run_and_drain();
        random_phase(60);

        set_torus(3, 7, 2, 5, BYTES_W'($urandom()));
        hold_off = 300;
        random_phase(70);

        for (int p = 0; p < 4; p++)
        begin
            set_torus($urandom_range(1, 256), $urandom_range(1, 16),
                      $urandom_range(1, 9), $urandom_range(0, 300),
                      BYTES_W'($urandom()));
            random_phase(45);
        end
        set_torus(1, 1, 1, 1, 31'h2aaa_aaaa);
        random_phase(10);

        stimulus_done = 1'b1;
    end

    // driver
    int in_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            source_rank <= '0;
            in_gap      <= 0;
        end
        else if (in_taken)
        begin
            // beat taken at the last rising edge
            void'(pending_ranks.pop_front());
            in_valid <= 1'b0;
            in_gap   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (pending_ranks.size() != 0 && $urandom_range(0, 1) == 0)
            begin
                in_valid    <= 1'b1;
                source_rank <= pending_ranks[0];
                in_gap      <= 0;
            end
        end
        else if (!in_valid)
        begin
            if (in_gap > 0)
                in_gap <= in_gap - 1;
            else if (pending_ranks.size() != 0)
            begin
                in_valid    <= 1'b1;
                source_rank <= pending_ranks[0];
            end
        end
    end

    // prediction is made at acceptance so it uses the live register copy
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_neighbours(source_rank);
    end

    // receiver stall
    int out_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            out_gap   <= 0;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off  <= hold_off - 1;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap   <= out_gap - 1;
        end
        else if (out_valid && !out_stall)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b1;
                out_gap   <= $urandom_range(0, 17);
            end
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            edge_beat_t exp_b;
            if (expected_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat from_rank=%h dir=%0d", from_rank, direction);
            end
            else
            begin
                exp_b = expected_edges.pop_front();
                if (from_rank !== exp_b.from_rank || neighbor_rank !== exp_b.neighbor_rank ||
                    edge_bytes !== exp_b.edge_bytes || direction !== exp_b.direction ||
                    out_of_range !== exp_b.out_of_range ||
                    last_of_run !== exp_b.last_of_run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp rank=%h nb=%h bytes=%h dir=%0d oor=%b last=%b",
                                 exp_b.from_rank, exp_b.neighbor_rank, exp_b.edge_bytes,
                                 exp_b.direction, exp_b.out_of_range, exp_b.last_of_run);
                        $display("         got rank=%h nb=%h bytes=%h dir=%0d oor=%b last=%b",
                                 from_rank, neighbor_rank, edge_bytes, direction,
                                 out_of_range, last_of_run);
                    end
                end
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        mismatches  = 0;
        idle_cycles = 0;
        hold_off    = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stimulus_done)
            begin
                if (mismatches == 0 && expected_edges.size() == 0)
                    $display("No mismatches found");
                else
                    $display("Mismatches found");
                $finish;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

/* torus_4d_neighbor_ranks_unit.f */
sv/tn4_pkg.sv
sv/tn4_cfg.sv
sv/tn4_div_stage.sv
sv/tn4_emit.sv
sv/torus_4d_neighbor_ranks_unit.sv
verif/torus_4d_neighbor_ranks_unit_tb.sv
